/* design/imc_pkg.sv */
// ----------------------------------------------------------------------------
// imc_pkg
// shared types and constants for the pending/mask interrupt controller
// ----------------------------------------------------------------------------
package imc_pkg;

  localparam int unsigned NUM_SOURCES   = 6;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned SRC_W         = 3;
  localparam int unsigned MODE_CLR5_BIT = 11;

  localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0202_0102;

  // transaction kinds
  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_SET_PEND  = 2'd2,
    ACT_CLR_PEND  = 2'd3
  } action_t;

  // register select, byte address bits 3:2
  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_VERSION = 2'd1,
    REG_PENDING = 2'd2,
    REG_MASK    = 2'd3
  } reg_sel_t;

  typedef logic [NUM_SOURCES-1:0] src_vec_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   byte_address;
    logic [DATA_W-1:0]   write_data;
    logic [SRC_W-1:0]    source;
  } item_t;

endpackage

/* design/interrupt_mask_controller_core.sv */
// ----------------------------------------------------------------------------
// interrupt_mask_controller_core
// pending/mask interrupt controller with mode, version, pending, mask registers
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one transaction: a register
//   read, a register write, or a set / clear event for one pending source
//   result channel (out_valid / out_stall) returns one transaction for every
//   input: read data (zero unless a read) and the irq level after the update
//   path: an accepted transaction passes through the input register and
//   then the result register, which shows it on the result channel
//   throughput: one transaction per cycle while the receiver does not stall,
//   set by the single update path between the input and result registers
//   when the receiver stalls the result register holds, the input register
//   keeps one more transaction and in_stall rises only once both are full
//   reset (rst_n low, synchronous) clears mode, pending, mask and both
//   valid flags; the version register is constant
// ----------------------------------------------------------------------------
module interrupt_mask_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [imc_pkg::ADDR_W-1:0]   in_byte_address,
  input  logic [imc_pkg::DATA_W-1:0]   in_write_data,
  input  logic [imc_pkg::SRC_W-1:0]    in_source,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [imc_pkg::DATA_W-1:0]   out_read_data,
  output logic                         out_irq
);
  import imc_pkg::*;

  // transaction held in the input register
  logic  item_valid;
  item_t item;
  // input register emptied into the result register this cycle
  logic  take;

  imc_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_byte_address (in_byte_address),
    .in_write_data   (in_write_data),
    .in_source       (in_source),
    .take            (take),
    .item_valid      (item_valid),
    .item            (item)
  );

  // state update happens as the transaction moves into the result register
  imc_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_irq       (out_irq)
  );

endmodule

/* design/imc_in_stage.sv */
// ----------------------------------------------------------------------------
// imc_in_stage
// input register: captures one transaction and holds it until taken
// ----------------------------------------------------------------------------
module imc_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [imc_pkg::ADDR_W-1:0]   in_byte_address,
  input  logic [imc_pkg::DATA_W-1:0]   in_write_data,
  input  logic [imc_pkg::SRC_W-1:0]    in_source,
  input  logic                         take,
  output logic                         item_valid,
  output imc_pkg::item_t               item
);
  import imc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  ready;

  // empty or being emptied this cycle
  assign ready    = !valid_r || take;
  assign in_stall = !ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      item_r.action       <= action_t'(in_action);
      item_r.byte_address <= in_byte_address;
      item_r.write_data   <= in_write_data;
      item_r.source       <= in_source;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* design/imc_regs.sv */
// ----------------------------------------------------------------------------
// imc_regs
// register file, pending/mask update and result register
// ----------------------------------------------------------------------------
module imc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  imc_pkg::item_t               item,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [imc_pkg::DATA_W-1:0]   out_read_data,
  output logic                         out_irq
);
  import imc_pkg::*;

  logic [DATA_W-1:0] mode_r, mode_nxt;
  src_vec_t          pend_r, pend_nxt;
  src_vec_t          mask_r, mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic              irq_r, irq_nxt;

  reg_sel_t          sel;
  src_vec_t          src_dec;
  logic              out_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign take      = item_valid && out_ready;
  assign sel       = reg_sel_t'(item.byte_address[3:2]);

  // one-hot source, sources 6 and 7 decode to nothing
  always_comb begin
    src_dec = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (item.source == SRC_W'(i)) begin
        src_dec[i] = 1'b1;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    mask_nxt  = mask_r;
    rdata_nxt = '0;
    unique case (item.action)
      ACT_READ: begin
        unique case (sel)
          REG_MODE:    rdata_nxt = mode_r;
          REG_VERSION: rdata_nxt = VERSION_WORD;
          REG_PENDING: rdata_nxt = DATA_W'(pend_r);
          REG_MASK:    rdata_nxt = DATA_W'(mask_r);
          default:     rdata_nxt = '0;
        endcase
      end
      ACT_WRITE: begin
        if (sel == REG_MODE) begin
          mode_nxt = item.write_data;
          if (item.write_data[MODE_CLR5_BIT]) begin
            pend_nxt[NUM_SOURCES-1] = 1'b0;
          end
        end else if (sel == REG_MASK) begin
          // clear bit wins over set bit
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (item.write_data[2*i]) begin
              mask_nxt[i] = 1'b0;
            end else if (item.write_data[2*i+1]) begin
              mask_nxt[i] = 1'b1;
            end
          end
        end
      end
      ACT_SET_PEND: pend_nxt = pend_r | src_dec;
      ACT_CLR_PEND: pend_nxt = pend_r & ~src_dec;
      default: ;
    endcase
    irq_nxt = |(pend_nxt & mask_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      pend_r      <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        mask_r <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rdata_r;
  assign out_irq       = irq_r;

endmodule

/* bench/interrupt_mask_controller_core_tb.sv */
// ----------------------------------------------------------------------------
// interrupt_mask_controller_core_tb
// self-checking bench for the pending/mask interrupt controller: directed
// register and event transactions, then random traffic under four idling
// phases, every result compared against a cycle-free model of the registers
// ----------------------------------------------------------------------------
module interrupt_mask_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imc_pkg::*;

  // run length guard, far beyond the slowest legal run of ~800 transactions
  localparam int unsigned CYCLE_LIMIT = 200000;
  // cycles to watch for stray results once the queue is empty
  localparam int unsigned TAIL_CYCLES = 8;
  // mismatch lines printed before going quiet (still counted)
  localparam int unsigned MAX_REPORTS = 40;
  // random transactions per idling phase
  localparam int unsigned PHASE_ITEMS = 190;

  // one result transaction as the block should show it
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
  } access_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_action = ACT_READ;
  logic [ADDR_W-1:0] in_byte_address = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic [SRC_W-1:0]  in_source = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic              out_irq;

  // model copy of the register file, starting from the reset values
  logic [DATA_W-1:0] mode_shadow = '0;
  src_vec_t          pend_shadow = '0;
  src_vec_t          mask_shadow = '0;

  // results owed by the block, oldest first
  access_result_t    access_results_q[$];

  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       snd_idle_pct = 0;
  int unsigned       rcv_stall_pct = 0;

  interrupt_mask_controller_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_byte_address (in_byte_address),
    .in_write_data   (in_write_data),
    .in_source       (in_source),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_irq         (out_irq)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model: apply one accepted transaction to the shadow registers and return
  // the read data and irq level the block must show for it
  // ---------------------------------------------------------------------------
  function automatic access_result_t apply_access(
    input action_t           act,
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_W-1:0] data,
    input logic [SRC_W-1:0]  src
  );
    access_result_t res;
    reg_sel_t       sel;
    res.read_data = '0;
    sel = reg_sel_t'(addr[3:2]);
    case (act)
      ACT_READ: begin
        case (sel)
          REG_MODE:    res.read_data = mode_shadow;
          REG_VERSION: res.read_data = VERSION_WORD;
          REG_PENDING: res.read_data = DATA_W'(pend_shadow);
          default:     res.read_data = DATA_W'(mask_shadow);
        endcase
      end
      ACT_WRITE: begin
        if (sel == REG_MODE) begin
          mode_shadow = data;
          // mode bit 11 acknowledges source 5
          if (data[MODE_CLR5_BIT]) pend_shadow[5] = 1'b0;
        end else if (sel == REG_MASK) begin
          // per source: even bit clears, odd bit sets, clear wins
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (data[2*i]) mask_shadow[i] = 1'b0;
            else if (data[2*i+1]) mask_shadow[i] = 1'b1;
          end
        end
        // version and pending writes fall through untouched
      end
      ACT_SET_PEND: begin
        if (src < NUM_SOURCES) pend_shadow[src] = 1'b1;
      end
      default: begin
        if (src < NUM_SOURCES) pend_shadow[src] = 1'b0;
      end
    endcase
    res.irq = |(pend_shadow & mask_shadow);
    return res;
  endfunction

  // one line per mismatch, quiet after a while but always counted
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch @%0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge; an input transaction
  // is predicted when accepted, a result transaction checked when taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        access_results_q.push_back(apply_access(action_t'(in_action), in_byte_address,
                                                in_write_data, in_source));
      if (out_valid && !out_stall) begin
        if (access_results_q.size() == 0) begin
          report_mismatch("unexpected result", out_read_data, '0);
        end else begin
          want = access_results_q.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
          if (out_irq !== want.irq)
            report_mismatch("irq", DATA_W'(out_irq), DATA_W'(want.irq));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure, decided per cycle on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // driver: optional idle cycles (with junk on the payload), then hold the
  // transaction until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_access(input action_t act, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [SRC_W-1:0] src);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_write_data <= $urandom;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_byte_address <= addr;
    in_write_data   <= data;
    in_source       <= src;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender holds off until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk);
  endtask

  // register address with random don't-care byte bits
  function automatic logic [ADDR_W-1:0] reg_addr(input reg_sel_t sel);
    return {sel, 2'($urandom_range(3))};
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // all four registers straight after reset, including the constant version
  task automatic test_reset_values();
    send_access(ACT_READ, {REG_MODE, 2'b00}, '1, '0);
    send_access(ACT_READ, {REG_VERSION, 2'b01}, '0, '1);
    send_access(ACT_READ, {REG_PENDING, 2'b10}, '1, '0);
    send_access(ACT_READ, {REG_MASK, 2'b11}, '0, '1);
  endtask

  // set-all pattern with junk in the ignored upper bits
  task automatic test_mask_write();
    send_access(ACT_WRITE, reg_addr(REG_MASK), 32'hFFFF_FAAA, '0);
    send_access(ACT_READ, reg_addr(REG_MASK), '0, '0);
  endtask

  // set / clear events, out-of-range sources 6 and 7 change nothing
  task automatic test_pending_events();
    send_access(ACT_SET_PEND, '0, '0, 3'd0);
    send_access(ACT_SET_PEND, '1, '1, 3'd5);
    send_access(ACT_SET_PEND, '0, '0, 3'd6);
    send_access(ACT_SET_PEND, '0, '0, 3'd7);
    send_access(ACT_READ, reg_addr(REG_PENDING), '0, '0);
    send_access(ACT_CLR_PEND, '0, '0, 3'd0);
    send_access(ACT_CLR_PEND, '0, '0, 3'd7);
  endtask

  // full word stored; bit 11 drops pending source 5, the rest leave it alone
  task automatic test_mode_write();
    send_access(ACT_WRITE, {REG_MODE, 2'b01}, 32'hFFFF_FFFF, '0);
    send_access(ACT_READ, reg_addr(REG_MODE), '0, '0);
    send_access(ACT_SET_PEND, '0, '0, 3'd5);
    send_access(ACT_WRITE, reg_addr(REG_MODE), 32'h0000_07FF, '0);
    send_access(ACT_READ, reg_addr(REG_PENDING), '0, '0);
  endtask

  // version and pending are read-only; then both-bits mask write, clear wins
  task automatic test_ignored_writes();
    send_access(ACT_WRITE, reg_addr(REG_VERSION), 32'hFFFF_FFFF, '0);
    send_access(ACT_WRITE, reg_addr(REG_PENDING), 32'h0000_0000, '0);
    send_access(ACT_READ, reg_addr(REG_VERSION), '0, '0);
    send_access(ACT_READ, reg_addr(REG_PENDING), '0, '0);
    send_access(ACT_WRITE, reg_addr(REG_MASK), 32'h0000_0FFF, '0);
    send_access(ACT_READ, reg_addr(REG_MASK), '0, '0);
    send_access(ACT_WRITE, reg_addr(REG_MODE), 32'h0000_0000, '0);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mixed reads, writes and events under each idling phase,
  // sender drained between phases
  // ---------------------------------------------------------------------------
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned pick;
    action_t     act;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) act = ACT_READ;
      else if (pick < 55) act = ACT_WRITE;
      else if (pick < 80) act = ACT_SET_PEND;
      else act = ACT_CLR_PEND;
      send_access(act, 4'($urandom_range(15)), $urandom, 3'($urandom_range(7)));
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    // no idling
    snd_idle_pct = 0;  rcv_stall_pct = 0;
    run_random_phase(PHASE_ITEMS);
    // sender mostly idle
    snd_idle_pct = 79; rcv_stall_pct = 0;
    run_random_phase(PHASE_ITEMS);
    // receiver mostly stalling
    snd_idle_pct = 0;  rcv_stall_pct = 79;
    run_random_phase(PHASE_ITEMS);
    // light idling on both sides
    snd_idle_pct = 16; rcv_stall_pct = 16;
    run_random_phase(PHASE_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_mask_write();
    test_pending_events();
    test_mode_write();
    test_ignored_writes();
    drain_results();

    test_random_traffic();

    // queue is empty; keep watching for stray results
    rcv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && access_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/imc_pkg.sv
design/imc_in_stage.sv
design/imc_regs.sv
design/interrupt_mask_controller_core.sv
bench/interrupt_mask_controller_core_tb.sv
